@@ src/fca_pkg.sv @@
// fca_pkg: shared sizes, codes and controller/datapath interface structs
// for the frequency ceiling arbiter. No dependencies.

package fca_pkg;

  // requester slots and usable table depth
  localparam int SLOT_COUNT  = 8;
  localparam int TABLE_DEPTH = 8;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // fixed field widths
  localparam int ENTRY_W = 3;
  localparam int FREQ_W  = 32;
  localparam int CFG_W   = 64;
  localparam int CNT_W   = 4;

  // no-limit ceiling
  localparam logic [FREQ_W-1:0] NO_LIMIT = '1;

  // configuration register indexes
  localparam logic [2:0] REG_TABLE_0_1   = 3'd0;
  localparam logic [2:0] REG_TABLE_2_3   = 3'd1;
  localparam logic [2:0] REG_TABLE_4_5   = 3'd2;
  localparam logic [2:0] REG_TABLE_6_7   = 3'd3;
  localparam logic [2:0] REG_ENTRIES_USE = 3'd4;
  localparam logic [2:0] REG_START_ENTRY = 3'd5;

  // register reset values
  localparam logic [CNT_W-1:0]   RST_ENTRIES_USE = 4'd8;
  localparam logic [ENTRY_W-1:0] RST_START_ENTRY = 3'd7;

  typedef enum logic [1:0] {
    ACT_SET     = 2'd0,
    ACT_REMOVE  = 2'd1,
    ACT_SUSPEND = 2'd2,
    ACT_RESUME  = 2'd3
  } fca_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_TAB,
    ST_DECIDE,
    ST_FREQ
  } fca_state_t;

  // controller to datapath
  typedef struct packed {
    logic               accept;
    logic               slot_step;
    logic [SLOT_W-1:0]  slot_sel;
    logic               tab_step;
    logic [ENTRY_W-1:0] tab_sel;
    logic               decide;
    logic               load_out;
  } fca_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic resolve;
  } fca_sts_t;

endpackage

@@ src/fca_ctrl.sv @@
// fca_ctrl: sequencer for the arbiter; runs the slot scan, the table scan,
// the decision and the result load. Depends on fca_pkg.

module fca_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fca_pkg::fca_sts_t sts,
  output fca_pkg::fca_cmd_t cmd
);

  fca_pkg::fca_state_t state_r, state_nxt;
  logic [fca_pkg::SLOT_W-1:0]  slot_cnt_r, slot_cnt_nxt;
  logic [fca_pkg::ENTRY_W-1:0] tab_cnt_r, tab_cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_last, tab_last, out_free;

  assign slot_last = (slot_cnt_r == fca_pkg::SLOT_W'(fca_pkg::SLOT_COUNT - 1));
  assign tab_last  = (tab_cnt_r == fca_pkg::ENTRY_W'(fca_pkg::TABLE_DEPTH - 1));
  assign out_free  = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fca_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = fca_pkg::ST_SLOT;
      end
      fca_pkg::ST_SLOT: begin
        if (slot_last) state_nxt = sts.resolve ? fca_pkg::ST_TAB : fca_pkg::ST_FREQ;
      end
      fca_pkg::ST_TAB: begin
        if (tab_last) state_nxt = fca_pkg::ST_DECIDE;
      end
      fca_pkg::ST_DECIDE: begin
        state_nxt = fca_pkg::ST_FREQ;
      end
      fca_pkg::ST_FREQ: begin
        if (out_free) state_nxt = fca_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fca_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd           = '0;
    cmd.slot_sel  = slot_cnt_r;
    cmd.tab_sel   = tab_cnt_r;
    in_stall      = 1'b1;
    slot_cnt_nxt  = slot_cnt_r;
    tab_cnt_nxt   = tab_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      fca_pkg::ST_IDLE: begin
        in_stall     = !rst_n;
        cmd.accept   = in_valid;
        slot_cnt_nxt = '0;
        tab_cnt_nxt  = '0;
      end
      fca_pkg::ST_SLOT: begin
        cmd.slot_step = 1'b1;
        slot_cnt_nxt  = slot_last ? '0 : slot_cnt_r + 1'b1;
      end
      fca_pkg::ST_TAB: begin
        cmd.tab_step = 1'b1;
        tab_cnt_nxt  = tab_last ? '0 : tab_cnt_r + 1'b1;
      end
      fca_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
      end
      fca_pkg::ST_FREQ: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fca_pkg::ST_IDLE;
      slot_cnt_r  <= '0;
      tab_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_cnt_r  <= slot_cnt_nxt;
      tab_cnt_r   <= tab_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/fca_dp.sv @@
// fca_dp: arbiter datapath; slot store, frequency table registers, scan
// compare units, entry in force and result registers. Depends on fca_pkg.

module fca_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fca_pkg::fca_cmd_t            cmd,
  output fca_pkg::fca_sts_t            sts,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [fca_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [1:0]                   in_action,
  input  logic [2:0]                   in_slot_index,
  input  logic [fca_pkg::FREQ_W-1:0]   in_ceiling_value,
  output logic                         out_target_issued,
  output logic [fca_pkg::ENTRY_W-1:0]  out_current_entry,
  output logic [fca_pkg::FREQ_W-1:0]   out_current_frequency,
  output logic                         out_is_suspended,
  output logic [fca_pkg::FREQ_W-1:0]   out_lowest_ceiling
);

  localparam int SC = fca_pkg::SLOT_COUNT;

  logic                          slot_valid_r [SC];
  logic [fca_pkg::FREQ_W-1:0]    slot_ceil_r  [SC];
  logic [fca_pkg::CFG_W-1:0]     table_r      [4];
  logic [fca_pkg::CNT_W-1:0]     use_cnt_r;
  logic [fca_pkg::ENTRY_W-1:0]   start_r;
  logic [fca_pkg::ENTRY_W-1:0]   entry_now_r;
  logic                          known_r;
  logic                          susp_r;
  logic                          resolve_r;
  logic                          issued_r;
  logic [fca_pkg::FREQ_W-1:0]    lowest_r;
  logic [fca_pkg::ENTRY_W-1:0]   best_r;

  logic                          slot_ok;
  logic [fca_pkg::SLOT_W-1:0]    slot_wr;
  logic [fca_pkg::ENTRY_W-1:0]   in_force;
  logic [fca_pkg::ENTRY_W-1:0]   rd_addr;
  logic [fca_pkg::CFG_W-1:0]     rd_pair;
  logic [fca_pkg::FREQ_W-1:0]    rd_freq;
  logic [fca_pkg::CNT_W-1:0]     n_eff;
  logic [fca_pkg::FREQ_W-1:0]    scan_ceil;
  fca_pkg::fca_action_t          act;

  assign act      = fca_pkg::fca_action_t'(in_action);
  assign slot_ok  = (32'(in_slot_index) < SC);
  assign slot_wr  = fca_pkg::SLOT_W'(in_slot_index);
  assign in_force = known_r ? entry_now_r : start_r;
  assign n_eff    = (use_cnt_r > fca_pkg::CNT_W'(fca_pkg::TABLE_DEPTH)) ?
                    fca_pkg::CNT_W'(fca_pkg::TABLE_DEPTH) : use_cnt_r;
  assign sts.resolve = resolve_r;

  // single table read port: scan index during the table scan, else entry in force
  assign rd_addr   = cmd.tab_step ? cmd.tab_sel : in_force;
  assign rd_pair   = table_r[rd_addr[2:1]];
  assign rd_freq   = rd_addr[0] ? rd_pair[63:32] : rd_pair[31:0];
  assign scan_ceil = slot_ceil_r[cmd.slot_sel];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) table_r[i] <= '0;
      use_cnt_r <= fca_pkg::RST_ENTRIES_USE;
      start_r   <= fca_pkg::RST_START_ENTRY;
    end else if (cfg_we) begin
      case (cfg_index)
        fca_pkg::REG_TABLE_0_1:   table_r[0] <= cfg_wdata;
        fca_pkg::REG_TABLE_2_3:   table_r[1] <= cfg_wdata;
        fca_pkg::REG_TABLE_4_5:   table_r[2] <= cfg_wdata;
        fca_pkg::REG_TABLE_6_7:   table_r[3] <= cfg_wdata;
        fca_pkg::REG_ENTRIES_USE: use_cnt_r  <= cfg_wdata[fca_pkg::CNT_W-1:0];
        fca_pkg::REG_START_ENTRY: start_r    <= cfg_wdata[fca_pkg::ENTRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // slot ceilings, written on a set transaction
  always_ff @(posedge clk) begin
    if (cmd.accept && act == fca_pkg::ACT_SET && slot_ok) begin
      slot_ceil_r[slot_wr] <= in_ceiling_value;
    end
  end

  // slot valid bits, suspend flag and resolve request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SC; i++) slot_valid_r[i] <= 1'b0;
      susp_r    <= 1'b0;
      resolve_r <= 1'b0;
    end else if (cmd.accept) begin
      resolve_r <= 1'b0;
      case (act)
        fca_pkg::ACT_SET: begin
          if (slot_ok) begin
            slot_valid_r[slot_wr] <= 1'b1;
            resolve_r             <= 1'b1;
          end
        end
        fca_pkg::ACT_REMOVE: begin
          if (slot_ok) begin
            slot_valid_r[slot_wr] <= 1'b0;
            resolve_r             <= 1'b1;
          end
        end
        fca_pkg::ACT_SUSPEND: begin
          susp_r <= 1'b1;
        end
        fca_pkg::ACT_RESUME: begin
          if (susp_r) begin
            susp_r    <= 1'b0;
            resolve_r <= 1'b1;
          end
        end
        default: begin
          resolve_r <= 1'b0;
        end
      endcase
    end
  end

  // lowest ceiling scan, then highest fitting table entry scan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lowest_r <= fca_pkg::NO_LIMIT;
      best_r   <= '0;
    end else if (cmd.slot_step) begin
      if (slot_valid_r[cmd.slot_sel] && scan_ceil != fca_pkg::NO_LIMIT &&
          scan_ceil < lowest_r) begin
        lowest_r <= scan_ceil;
      end
    end else if (cmd.tab_step) begin
      if ({1'b0, cmd.tab_sel} < n_eff && rd_freq <= lowest_r) begin
        best_r <= cmd.tab_sel;
      end
    end
  end

  // entry in force and target issue decision
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_now_r <= '0;
      known_r     <= 1'b0;
      issued_r    <= 1'b0;
    end else if (cmd.accept) begin
      issued_r <= 1'b0;
    end else if (cmd.decide) begin
      if (best_r != in_force && !susp_r) begin
        entry_now_r <= best_r;
        known_r     <= 1'b1;
        issued_r    <= 1'b1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_target_issued     <= issued_r;
      out_current_entry     <= in_force;
      out_current_frequency <= rd_freq;
      out_is_suspended      <= susp_r;
      out_lowest_ceiling    <= lowest_r;
    end
  end

endmodule

@@ src/frequency_ceiling_arbiter.sv @@
// frequency_ceiling_arbiter: top level; joins the fca_ctrl sequencer and the
// fca_dp datapath. Depends on fca_pkg, fca_ctrl and fca_dp.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   input    | in_valid, in_stall, in_action,          | in
//            | in_slot_index, in_ceiling_value         |
//   result   | out_valid, out_stall, out_target_issued, | out
//            | out_current_entry, out_current_frequency,|
//            | out_is_suspended, out_lowest_ceiling    |
//   config   | cfg_we, cfg_index, cfg_wdata            | in
//
// One transaction at a time: the accept, the slot scan over SLOT_COUNT slots,
// then the table scan over TABLE_DEPTH entries and the decision when the
// action re-resolves, then the result load. The slots and the table are
// walked one per cycle. The next transaction is taken the cycle after.
// Reset is synchronous, active low; in_stall is high while in reset.
// A stalled result holds in the output register while the next transaction
// runs; only the final load waits for the output register to free up.

module frequency_ceiling_arbiter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [2:0]                   in_slot_index,
  input  logic [fca_pkg::FREQ_W-1:0]   in_ceiling_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_target_issued,
  output logic [fca_pkg::ENTRY_W-1:0]  out_current_entry,
  output logic [fca_pkg::FREQ_W-1:0]   out_current_frequency,
  output logic                         out_is_suspended,
  output logic [fca_pkg::FREQ_W-1:0]   out_lowest_ceiling,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [fca_pkg::CFG_W-1:0]    cfg_wdata
);

  fca_pkg::fca_cmd_t cmd;
  fca_pkg::fca_sts_t sts;

  fca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fca_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_action             (in_action),
    .in_slot_index         (in_slot_index),
    .in_ceiling_value      (in_ceiling_value),
    .out_target_issued     (out_target_issued),
    .out_current_entry     (out_current_entry),
    .out_current_frequency (out_current_frequency),
    .out_is_suspended      (out_is_suspended),
    .out_lowest_ceiling    (out_lowest_ceiling)
  );

  // an accepted transaction keeps the input side busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction was in progress");

  // a new result only appears at the end of a transaction, never from idle
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in progress");

  // targets are withheld while suspended
  a_no_issue_suspended: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_target_issued) |-> !out_is_suspended)
    else $error("target issued while suspended");

endmodule
